// ===== rtl/core/smn_pkg.sv =====
// Package with shared types, constants and the exponential table for the softmax normalizer.
package smn_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int SCORE_W = 16;
  localparam int EXP_W = 17;
  localparam int SUM_W = EXP_W + IDX_W;
  localparam int PROB_W = 17;
  localparam int DIV_W = EXP_W + 16;
  localparam int STEP_W = $clog2(DIV_W + 1);
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EXP_RD,
    ST_EXP_CALC,
    ST_DIV_RD,
    ST_DIV_RUN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [EXP_W-1:0] numer;
    logic [SUM_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [PROB_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // The table is evaluated at elaboration with exact integer arithmetic in Q62.
  function automatic logic [256*EXP_W-1:0] build_exp_table();
    logic [63:0] root [8];
    logic [63:0] y;
    logic [63:0] cand;
    logic [63:0] sq;
    logic [63:0] p;
    logic [256*EXP_W-1:0] tbl;
    tbl = '0;
    for (int b = 0; b < 8; b++) begin
      y = '0;
      for (int bt = 61; bt >= 0; bt--) begin
        cand = y | (64'd1 << bt);
        sq = cand;
        for (int m = 0; m < 8 - b; m++) begin
          sq = q62_mul(sq, sq);
        end
        if (sq <= (64'd1 << 61)) begin
          y = cand;
        end
      end
      root[b] = y;
    end
    for (int f = 0; f < 256; f++) begin
      p = 64'd1 << 62;
      for (int b = 0; b < 8; b++) begin
        if (((f >> b) & 1) != 0) begin
          p = q62_mul(p, root[b]);
        end
      end
      tbl[f*EXP_W +: EXP_W] = EXP_W'((p + (64'd1 << 45)) >> 46);
    end
    return tbl;
  endfunction

  localparam logic [256*EXP_W-1:0] EXP_TABLE = build_exp_table();

  function automatic logic [16:0] exp_table(input logic [7:0] f);
    return EXP_TABLE[int'(f)*EXP_W +: EXP_W];
  endfunction

endpackage

// ===== rtl/core/smn_divider.sv =====
// Restoring radix-2 divider producing floor(numer * 65536 / denom), one bit a cycle.
module smn_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  smn_pkg::div_req_t req,
  output smn_pkg::div_rsp_t rsp
);
  import smn_pkg::*;

  logic [DIV_W-1:0] dividend_r, dividend_nxt;
  logic [SUM_W:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] denom_r, denom_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [SUM_W:0] trial;

  always_comb begin
    dividend_nxt = dividend_r;
    rem_nxt = rem_r;
    denom_nxt = denom_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[SUM_W-1:0], dividend_r[DIV_W-1]};
    if (req.start) begin
      dividend_nxt = {req.numer, 16'd0};
      rem_nxt = '0;
      denom_nxt = req.denom;
      step_nxt = STEP_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, denom_r}) begin
        rem_nxt = trial - {1'b0, denom_r};
        dividend_nxt = {dividend_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        dividend_nxt = {dividend_r[DIV_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dividend_r <= dividend_nxt;
    rem_r <= rem_nxt;
    denom_r <= denom_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = dividend_r[PROB_W-1:0];

endmodule

// ===== rtl/core/softmax_normalizer.sv =====
// Top level of the softmax normalizer: storage, exponent pass and division sequencer.
//
//   channel | direction | tdata                  | tuser/tlast
//   in_     | slave     | [15:0] score (signed)  | tlast = is_last
//   out_    | master    | [16:0] probability     | tlast = is_final
//
// Each element is written to the score store as it is accepted. After the last one,
// the exponent pass reads each element from the store, then computes its exp, and the
// divide pass runs each element through the one-bit-a-cycle divider shared by all.
// Reset is synchronous, active low; the stores need no clearing.
// The input is not ready while the passes run; a stalled result holds the sequencer.
module softmax_normalizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] score
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] probability, zero filled above
  output logic        out_tlast
);
  import smn_pkg::*;

  logic [SCORE_W-1:0] score_mem [MAX_ELEMENTS];
  logic [EXP_W-1:0] exp_mem [MAX_ELEMENTS];

  state_t state_r, state_nxt;
  logic signed [SCORE_W-1:0] max_r, max_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SCORE_W-1:0] score_rd_r;
  logic [EXP_W-1:0] exp_rd_r;
  logic [PROB_W-1:0] prob_r, prob_nxt;
  logic last_r, last_nxt;

  logic in_acc;
  logic score_we, exp_we;
  logic [EXP_W-1:0] exp_val;
  logic [15:0] diff;
  logic [32:0] prod;
  logic [16:0] t_val;
  logic [IDX_W-1:0] last_idx;
  div_req_t dreq;
  div_rsp_t drsp;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc = in_tvalid && in_tready;
  assign last_idx = IDX_W'(cnt_r - 1'b1);

  assign diff = 16'(max_r - $signed(score_rd_r));
  assign prod = diff * LOG2E_Q16 + 33'd32768;
  assign t_val = prod[32:16];

  always_comb begin
    if (t_val[16:8] >= 9'd17) begin
      exp_val = '0;
    end else begin
      exp_val = exp_table(t_val[7:0]) >> t_val[12:8];
    end
  end

  always_comb begin
    state_nxt = state_r;
    max_nxt = max_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    prob_nxt = prob_r;
    last_nxt = last_r;
    score_we = 1'b0;
    exp_we = 1'b0;
    dreq.start = 1'b0;
    dreq.numer = exp_rd_r;
    dreq.denom = sum_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          score_we = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if ($signed(in_tdata) > max_r) begin
            max_nxt = $signed(in_tdata);
          end
          if (in_tlast || cnt_r == CNT_W'(MAX_ELEMENTS - 1)) begin
            idx_nxt = '0;
            sum_nxt = '0;
            state_nxt = ST_EXP_RD;
          end
        end
      end
      ST_EXP_RD: begin
        state_nxt = ST_EXP_CALC;
      end
      ST_EXP_CALC: begin
        exp_we = 1'b1;
        sum_nxt = sum_r + SUM_W'(exp_val);
        if (idx_r == last_idx) begin
          idx_nxt = '0;
          state_nxt = ST_DIV_RD;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = ST_EXP_RD;
        end
      end
      ST_DIV_RD: begin
        state_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (!drsp.busy && !drsp.done) begin
          dreq.start = 1'b1;
        end
        if (drsp.done) begin
          prob_nxt = drsp.quot;
          last_nxt = (idx_r == last_idx);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          if (last_r) begin
            max_nxt = 16'sh8000;
            sum_nxt = '0;
            cnt_nxt = '0;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = ST_DIV_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      max_r <= 16'sh8000;
      sum_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
      last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      max_r <= max_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      last_r <= last_nxt;
    end
    prob_r <= prob_nxt;
  end

  always_ff @(posedge clk) begin
    if (score_we) begin
      score_mem[cnt_r[IDX_W-1:0]] <= in_tdata;
    end
    score_rd_r <= score_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (exp_we) begin
      exp_mem[idx_r] <= exp_val;
    end
    exp_rd_r <= exp_mem[idx_r];
  end

  smn_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata = {7'd0, prob_r};
  assign out_tlast = last_r;

endmodule
